@@ rtl/worley_noise_nearest_point_unit_defines.svh @@
// Assertion macros shared by the Worley noise nearest point files.
`ifndef WORLEY_NOISE_NEAREST_POINT_UNIT_DEFINES_SVH
`define WORLEY_NOISE_NEAREST_POINT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define WNP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define WNP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wnp_pkg.sv @@
package wnp_pkg;

  localparam int COORD_W   = 16;
  localparam int PIX_W     = 12;
  localparam int FRAC_BITS = 4;
  localparam int D2_W      = 33;
  localparam int DIST_W    = 17;
  localparam int GREY_W    = 8;
  localparam int SCALE_W   = 12;
  localparam int NPTS_W    = 5;
  localparam int PIDX_W    = 4;

  localparam logic [GREY_W-1:0] FULL_GREY = 8'd255;

  localparam logic CFG_POINTS_IN_USE  = 1'b0;
  localparam logic CFG_DISTANCE_SCALE = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [GREY_W-1:0] intensity;
    logic [DIST_W-1:0] nearest_distance;
    logic              saturated;
  } wnp_result_t;

endpackage

@@ rtl/wnp_point_table.sv @@
module wnp_point_table
  import wnp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  logic [2*COORD_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output logic [2*COORD_W-1:0] rd_data_o
);

  logic [2*COORD_W-1:0] mem [DEPTH];
  logic [2*COORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/wnp_root_div.sv @@
`include "worley_noise_nearest_point_unit_defines.svh"

module wnp_root_div
  import wnp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [D2_W-1:0]   d2_i,
  input  logic [COORD_W-1:0] scale_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  logic              res_ack_i,
  output wnp_result_t       res_o
);

  localparam int OP_W   = 25;
  localparam int RAD_W  = D2_W + 1;
  localparam int DVS_W  = COORD_W + GREY_W - 1;
  localparam int ROOT_STEPS = RAD_W / 2;

  typedef enum logic [2:0] {
    U_IDLE,
    U_ROOT,
    U_SAT,
    U_SCALE,
    U_DIV,
    U_DONE
  } ustate_e;

  ustate_e              st_q;
  logic [4:0]           cnt_q;
  logic [RAD_W-1:0]     rad_q;
  logic [OP_W-1:0]      acc_q;
  logic [DIST_W-1:0]    root_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [GREY_W-1:0]    quo_q;
  logic                 sat_q;
  logic [COORD_W-1:0]   scale_q;

  logic [OP_W-1:0]      op_a;
  logic [OP_W-1:0]      op_b;
  logic [OP_W:0]        diff;
  logic                 ge;

  always_comb begin
    case (st_q)
      U_ROOT: begin
        op_a = OP_W'({acc_q[DIST_W:0], rad_q[RAD_W-1 -: 2]});
        op_b = OP_W'({root_q, 2'b01});
      end
      U_SAT: begin
        op_a = OP_W'(root_q);
        op_b = OP_W'(scale_q);
      end
      U_SCALE: begin
        op_a = OP_W'({root_q[COORD_W-1:0], 8'd0});
        op_b = OP_W'(root_q);
      end
      U_DIV: begin
        op_a = acc_q;
        op_b = OP_W'(dvs_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = !diff[OP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= U_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        U_IDLE: begin
          if (start_i) begin
            st_q    <= U_ROOT;
            cnt_q   <= '0;
            rad_q   <= RAD_W'(d2_i);
            acc_q   <= '0;
            root_q  <= '0;
            scale_q <= scale_i;
          end
        end
        U_ROOT: begin
          if (ge) begin
            acc_q  <= diff[OP_W-1:0];
            root_q <= {root_q[DIST_W-2:0], 1'b1};
          end else begin
            acc_q  <= op_a;
            root_q <= {root_q[DIST_W-2:0], 1'b0};
          end
          rad_q <= {rad_q[RAD_W-3:0], 2'b00};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(ROOT_STEPS - 1)) begin
            st_q <= U_SAT;
          end
        end
        U_SAT: begin
          sat_q <= ge;
          st_q  <= ge ? U_DONE : U_SCALE;
        end
        U_SCALE: begin
          acc_q <= diff[OP_W-1:0];
          dvs_q <= {scale_q, 7'd0};
          quo_q <= '0;
          cnt_q <= '0;
          st_q  <= U_DIV;
        end
        U_DIV: begin
          if (ge) begin
            acc_q <= diff[OP_W-1:0];
          end
          quo_q <= {quo_q[GREY_W-2:0], ge};
          dvs_q <= {1'b0, dvs_q[DVS_W-1:1]};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(GREY_W - 1)) begin
            st_q <= U_DONE;
          end
        end
        U_DONE: begin
          if (res_ack_i) begin
            st_q <= U_IDLE;
          end
        end
        default: begin
          st_q <= U_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (st_q != U_IDLE);
  assign res_valid_o = (st_q == U_DONE);

  always_comb begin
    res_o.intensity        = sat_q ? FULL_GREY : quo_q;
    res_o.nearest_distance = root_q;
    res_o.saturated        = sat_q;
  end

  `WNP_CHECK(a_grey_below_full, res_valid_o && !res_o.saturated, res_o.intensity != FULL_GREY, "unsaturated grey reached full scale")
  `WNP_CHECK(a_start_when_idle, start_i, st_q == U_IDLE, "start while busy")
  `WNP_CHECK_NEXT(a_ack_frees, res_valid_o && res_ack_i, st_q == U_IDLE, "unit held after handoff")

endmodule

@@ rtl/worley_noise_nearest_point_unit.sv @@
// A load beat leaves the block in idle, so it stays ready for the next beat.
// A query walks the points in use, then takes the square root and, unless saturated,
// the division; the block is back in idle at the same edge that fills the output register,
// so the next query can then be taken; the shared 16x16 multiplier walks the table
// and one shared 25-bit subtractor runs the root, saturation test, scaling and division.
// Reset restores points_in_use to 10 and distance_scale to 400; the point table is not cleared.
`include "worley_noise_nearest_point_unit_defines.svh"

module worley_noise_nearest_point_unit
  import wnp_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_index, point_x, point_y, pixel_x, pixel_y, zero fill
  input  logic [63:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // intensity, nearest_distance, zero fill
  output logic [31:0] m_axis_tdata,
  // saturated
  output logic        m_axis_tuser
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_LAST,
    S_FINISH
  } state_e;

  state_e               st_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [IDX_W-1:0]     last_q;
  logic                 pend_q;
  logic [COORD_W-1:0]   px_q, py_q;
  logic [2*COORD_W-1:0] prod_q;
  logic [2*COORD_W-1:0] xsq_q;
  logic [D2_W-1:0]      best_q;
  logic [NPTS_W-1:0]    npts_q;
  logic [SCALE_W-1:0]   dscale_q;
  logic                 m_valid_q;
  wnp_result_t          m_res_q;

  logic [PIDX_W-1:0]    in_idx;
  logic [COORD_W-1:0]   in_point_x, in_point_y;
  logic [PIX_W-1:0]     in_pixel_x, in_pixel_y;
  logic                 in_acc;
  logic                 load_en;

  logic [2*COORD_W-1:0] rd_data;
  logic [COORD_W-1:0]   rd_x, rd_y;
  logic [COORD_W-1:0]   dx, dy, mul_op;
  logic [2*COORD_W-1:0] mul_res;
  logic [D2_W-1:0]      cand, best_d;

  logic [NPTS_W-1:0]    n_eff;
  logic [IDX_W-1:0]     last_d;
  logic [SCALE_W-1:0]   scale_eff;
  logic [COORD_W-1:0]   scale_fx;

  logic                 unit_start, unit_busy, unit_valid, unit_ack;
  wnp_result_t          unit_res;

  assign in_idx     = s_axis_tdata[3:0];
  assign in_point_x = s_axis_tdata[19:4];
  assign in_point_y = s_axis_tdata[35:20];
  assign in_pixel_x = s_axis_tdata[47:36];
  assign in_pixel_y = s_axis_tdata[59:48];

  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_en       = in_acc && (s_axis_tuser == CMD_LOAD)
                         && (32'(in_idx) < MAX_POINTS);

  assign idx_d = (st_q == S_SQY) ? idx_q + IDX_W'(1)
               : (st_q == S_IDLE) ? '0 : idx_q;

  wnp_point_table #(
    .DEPTH (MAX_POINTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (IDX_W'(in_idx)),
    .wr_data_i ({in_point_y, in_point_x}),
    .rd_addr_i (idx_d),
    .rd_data_o (rd_data)
  );

  assign rd_x    = rd_data[COORD_W-1:0];
  assign rd_y    = rd_data[2*COORD_W-1:COORD_W];
  assign dx      = (rd_x >= px_q) ? rd_x - px_q : px_q - rd_x;
  assign dy      = (rd_y >= py_q) ? rd_y - py_q : py_q - rd_y;
  assign mul_op  = (st_q == S_SQY) ? dy : dx;
  assign mul_res = (2*COORD_W)'(mul_op) * (2*COORD_W)'(mul_op);

  assign cand   = {1'b0, xsq_q} + {1'b0, prod_q};
  assign best_d = (pend_q && (cand < best_q)) ? cand : best_q;

  always_comb begin
    n_eff = (npts_q == '0) ? NPTS_W'(1) : npts_q;
    if (32'(n_eff) > MAX_POINTS) begin
      last_d = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_d = IDX_W'(n_eff - NPTS_W'(1));
    end
  end

  assign scale_eff = (dscale_q == '0) ? SCALE_W'(1) : dscale_q;
  assign scale_fx  = {scale_eff, FRAC_BITS'(0)};

  assign unit_start = (st_q == S_LAST);
  assign unit_ack   = (st_q == S_FINISH) && unit_valid && (!m_valid_q || m_axis_tready);

  wnp_root_div u_root_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (unit_start),
    .d2_i        (best_d),
    .scale_i     (scale_fx),
    .busy_o      (unit_busy),
    .res_valid_o (unit_valid),
    .res_ack_i   (unit_ack),
    .res_o       (unit_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      npts_q    <= NPTS_W'(10);
      dscale_q  <= SCALE_W'(400);
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POINTS_IN_USE:  npts_q   <= cfg_data_i[NPTS_W-1:0];
          CFG_DISTANCE_SCALE: dscale_q <= cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (unit_ack) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      idx_q <= idx_d;
      case (st_q)
        S_IDLE: begin
          if (in_acc && (s_axis_tuser == CMD_QUERY)) begin
            st_q   <= S_SQX;
            px_q   <= {in_pixel_x, FRAC_BITS'(0)};
            py_q   <= {in_pixel_y, FRAC_BITS'(0)};
            last_q <= last_d;
            best_q <= '1;
            pend_q <= 1'b0;
          end
        end
        S_SQX: begin
          best_q <= best_d;
          prod_q <= mul_res;
          st_q   <= S_SQY;
        end
        S_SQY: begin
          xsq_q  <= prod_q;
          prod_q <= mul_res;
          pend_q <= 1'b1;
          st_q   <= (idx_q == last_q) ? S_LAST : S_SQX;
        end
        S_LAST: begin
          st_q <= S_FINISH;
        end
        S_FINISH: begin
          if (unit_ack) begin
            m_res_q <= unit_res;
            st_q    <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 32'({m_res_q.nearest_distance, m_res_q.intensity});
  assign m_axis_tuser  = m_res_q.saturated;

  `WNP_CHECK(a_ready_unit_idle, s_axis_tready, !unit_busy, "input ready while root unit busy")
  `WNP_CHECK(a_walk_in_range, st_q == S_SQX || st_q == S_SQY, idx_q <= last_q, "walk index beyond last point")
  `WNP_CHECK_NEXT(a_ack_fills_out, unit_ack, m_axis_tvalid, "handoff did not fill output register")
  `WNP_CHECK_NEXT(a_start_busy, unit_start, unit_busy && st_q == S_FINISH, "root unit did not start")

endmodule
